// ----- src/tpa_pkg.sv -----
// Package: shared types, mode codes and helpers for the triangle primitive assembler.
`timescale 1ns / 1ps

package tpa_pkg;

    localparam int ATTR_WIDTH = 32;
    localparam int WORD_WIDTH = 32;
    localparam int ATTR_KEEP  = (ATTR_WIDTH < WORD_WIDTH) ? ATTR_WIDTH : WORD_WIDTH;

    localparam logic [3:0] TRI_LIST  = 4'd4;
    localparam logic [3:0] TRI_STRIP = 4'd5;
    localparam logic [3:0] TRI_FAN   = 4'd6;

    localparam logic [1:0] COUNT_MAX = 2'd3;
    localparam logic [1:0] LAST_BEAT = 2'd2;

    typedef logic [WORD_WIDTH-1:0] t_word;

    typedef struct packed {
        t_word      vertex_index;
        t_word      pos_x;
        t_word      pos_y;
        t_word      pos_z;
        t_word      norm_x;
        t_word      norm_y;
        t_word      norm_z;
        logic [3:0] draw_mode;
        logic       set_start;
    } t_in_beat;

    typedef struct packed {
        t_word out_index;
        t_word out_pos_x;
        t_word out_pos_y;
        t_word out_pos_z;
        t_word out_norm_x;
        t_word out_norm_y;
        t_word out_norm_z;
        logic  run_last;
    } t_out_beat;

    typedef struct packed {
        t_word idx;
        t_word px;
        t_word py;
        t_word pz;
        t_word nx;
        t_word ny;
        t_word nz;
    } t_vertex;

    typedef struct packed {
        t_vertex v0;
        t_vertex v1;
        t_vertex v2;
        logic    triple;
    } t_job;

    function automatic t_word attr_mask();
        logic [2*WORD_WIDTH-1:0] m;
        m = ({{WORD_WIDTH{1'b0}}, {WORD_WIDTH{1'b1}}}) >> (WORD_WIDTH - ATTR_KEEP);
        return m[WORD_WIDTH-1:0];
    endfunction

    function automatic t_out_beat to_beat(input t_vertex v, input logic last);
        t_out_beat b;
        b.out_index  = v.idx;
        b.out_pos_x  = v.px;
        b.out_pos_y  = v.py;
        b.out_pos_z  = v.pz;
        b.out_norm_x = v.nx;
        b.out_norm_y = v.ny;
        b.out_norm_z = v.nz;
        b.run_last   = last;
        return b;
    endfunction

endpackage

// ----- src/tpa_front.sv -----
// Front end: accepts vertices, tracks set history and builds one job per supported vertex.
`timescale 1ns / 1ps

module tpa_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  tpa_pkg::t_in_beat i_in_beat,
    input  logic              i_q_full,
    output logic              o_push,
    output tpa_pkg::t_job     o_job
);

    tpa_pkg::t_vertex r_older, n_older;
    tpa_pkg::t_vertex r_newer, n_newer;
    tpa_pkg::t_vertex r_centre, n_centre;
    logic [1:0]       r_count, n_count;
    logic             r_parity, n_parity;

    tpa_pkg::t_vertex cur;
    tpa_pkg::t_word   mask;
    logic             supported;
    logic             accept;
    logic [1:0]       pos;
    logic             par;
    tpa_pkg::t_vertex centre_use;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    always_comb begin
        mask   = tpa_pkg::attr_mask();
        cur.idx = i_in_beat.vertex_index;
        cur.px  = i_in_beat.pos_x  & mask;
        cur.py  = i_in_beat.pos_y  & mask;
        cur.pz  = i_in_beat.pos_z  & mask;
        cur.nx  = i_in_beat.norm_x & mask;
        cur.ny  = i_in_beat.norm_y & mask;
        cur.nz  = i_in_beat.norm_z & mask;

        supported = (i_in_beat.draw_mode == tpa_pkg::TRI_LIST) ||
                    (i_in_beat.draw_mode == tpa_pkg::TRI_STRIP) ||
                    (i_in_beat.draw_mode == tpa_pkg::TRI_FAN);

        pos = i_in_beat.set_start ? 2'd0 : r_count;
        par = i_in_beat.set_start ? 1'b0 : r_parity;
        centre_use = (pos == 2'd0) ? cur : r_centre;

        o_push     = accept && supported;
        o_job.v2   = cur;
        o_job.triple = (i_in_beat.draw_mode != tpa_pkg::TRI_LIST) &&
                       (pos == tpa_pkg::COUNT_MAX);
        if (i_in_beat.draw_mode == tpa_pkg::TRI_STRIP) begin
            o_job.v0 = par ? r_newer : r_older;
            o_job.v1 = par ? r_older : r_newer;
        end else begin
            o_job.v0 = centre_use;
            o_job.v1 = r_newer;
        end

        n_older  = r_older;
        n_newer  = r_newer;
        n_centre = r_centre;
        n_count  = r_count;
        n_parity = r_parity;
        if (o_push) begin
            n_older  = r_newer;
            n_newer  = cur;
            n_centre = centre_use;
            n_count  = (pos == tpa_pkg::COUNT_MAX) ? tpa_pkg::COUNT_MAX : pos + 2'd1;
            n_parity = ~par;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_older  <= '0;
            r_newer  <= '0;
            r_centre <= '0;
            r_count  <= '0;
            r_parity <= 1'b0;
        end else begin
            r_older  <= n_older;
            r_newer  <= n_newer;
            r_centre <= n_centre;
            r_count  <= n_count;
            r_parity <= n_parity;
        end
    end

endmodule

// ----- src/tpa_queue.sv -----
// Job queue: two-entry FIFO between the front end and the emitter.
`timescale 1ns / 1ps

module tpa_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tpa_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_nonempty,
    output tpa_pkg::t_job o_head
);

    tpa_pkg::t_job r_mem [2];
    logic          r_wr_ptr, n_wr_ptr;
    logic          r_rd_ptr, n_rd_ptr;
    logic [1:0]    r_count, n_count;
    logic          do_push;
    logic          do_pop;

    assign o_full     = (r_count == 2'd2);
    assign o_nonempty = (r_count != 2'd0);
    assign o_head     = r_mem[r_rd_ptr];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_nonempty;

    always_comb begin
        n_wr_ptr = do_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ----- src/tpa_back.sv -----
// Emitter: walks each queued job out as one or three registered output beats.
`timescale 1ns / 1ps

module tpa_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_nonempty,
    input  tpa_pkg::t_job      i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tpa_pkg::t_out_beat o_out_beat
);

    logic               r_valid, n_valid;
    tpa_pkg::t_out_beat r_beat_data, n_beat_data;
    logic [1:0]         r_beat, n_beat;
    logic               advance;
    logic               load;
    logic               last;

    assign advance     = !r_valid || !i_out_stall;
    assign load        = advance && i_nonempty;
    assign last        = !i_head.triple || (r_beat == tpa_pkg::LAST_BEAT);
    assign o_pop       = load && last;
    assign o_out_valid = r_valid;
    assign o_out_beat  = r_beat_data;

    always_comb begin
        n_valid     = r_valid;
        n_beat_data = r_beat_data;
        n_beat      = r_beat;
        if (advance) begin
            n_valid = load;
        end
        if (load) begin
            if (!i_head.triple) begin
                n_beat_data = tpa_pkg::to_beat(i_head.v2, 1'b1);
            end else begin
                case (r_beat)
                    2'd0:    n_beat_data = tpa_pkg::to_beat(i_head.v0, 1'b0);
                    2'd1:    n_beat_data = tpa_pkg::to_beat(i_head.v1, 1'b0);
                    default: n_beat_data = tpa_pkg::to_beat(i_head.v2, 1'b1);
                endcase
            end
            n_beat = last ? 2'd0 : r_beat + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_beat_data <= n_beat_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_beat  <= '0;
        end else begin
            r_valid <= n_valid;
            r_beat  <= n_beat;
        end
    end

endmodule

// ----- src/triangle_primitive_assembler.sv -----
// Top level: triangle strip and fan to triangle-list vertex assembler.
//
// Input channel (i_in_valid / o_in_stall / i_in_beat) takes one vertex per beat
// with its draw mode and set-start flag. Output channel (o_out_valid /
// i_out_stall / o_out_beat) gives triangle-list vertices; run_last marks the
// final vertex produced for one input beat.
// Triangle-list vertices and the first three vertices of a strip or fan set
// give one output beat; later strip or fan vertices give three. Other modes
// give none and leave the history untouched.
// Each accepted supported vertex is registered in the job queue, and each
// output beat in the emitter. Throughput: one output beat per cycle while the
// receiver does not stall, so one input beat per cycle for single-beat
// vertices; a full triangle gives three output beats. A two-entry job queue
// lets the input side run ahead. Reset clears the history, count, parity,
// queue and output valid flag, not the output beat data. While the receiver
// stalls the output beat holds; the queue fills, then o_in_stall rises.
`timescale 1ns / 1ps

module triangle_primitive_assembler (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tpa_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tpa_pkg::t_out_beat o_out_beat
);

    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_nonempty;
    tpa_pkg::t_job job_in;
    tpa_pkg::t_job job_head;

    tpa_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_beat  (i_in_beat),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_job      (job_in)
    );

    tpa_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_job      (job_in),
        .o_full     (q_full),
        .i_pop      (pop),
        .o_nonempty (q_nonempty),
        .o_head     (job_head)
    );

    tpa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_nonempty  (q_nonempty),
        .i_head      (job_head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

endmodule

// ----- tb/sv/tb_triangle_primitive_assembler.sv -----
// Testbench for the triangle primitive assembler: directed table, then random vertex sets.
`timescale 1ns / 1ps

module tb_triangle_primitive_assembler;

    localparam logic [3:0] MODE_POINTS     = 4'd0;
    localparam logic [3:0] MODE_LINES      = 4'd1;
    localparam logic [3:0] MODE_LINE_LOOP  = 4'd2;
    localparam logic [3:0] MODE_LINE_STRIP = 4'd3;
    localparam logic [3:0] MODE_QUADS      = 4'd7;
    localparam logic [3:0] MODE_QUAD_STRIP = 4'd8;
    localparam logic [3:0] MODE_POLYGON    = 4'd9;

    localparam tpa_pkg::t_word KEEP_MASK =
        {tpa_pkg::WORD_WIDTH{1'b1}} >> (tpa_pkg::WORD_WIDTH - tpa_pkg::ATTR_KEEP);
    localparam int    RANDOM_ITEMS  = 300;
    localparam int    QUIET_ITEMS   = 260;
    localparam int    DRAIN_CYCLES  = 20;
    localparam int    CYCLE_LIMIT   = 200000;

    typedef enum logic [1:0] {
        ROW_ECHO,
        ROW_DROP,
        ROW_MODEL
    } t_row_kind;

    typedef struct {
        tpa_pkg::t_in_beat beat;
        t_row_kind         kind;
    } t_vertex_row;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               o_in_stall;
    tpa_pkg::t_in_beat  in_beat;
    logic               o_out_valid;
    logic               out_stall;
    tpa_pkg::t_out_beat o_out_beat;

    tpa_pkg::t_vertex   hist_older;
    tpa_pkg::t_vertex   hist_newer;
    tpa_pkg::t_vertex   hist_centre;
    logic [1:0]         hist_count;
    logic               hist_parity;
    tpa_pkg::t_out_beat step_beats [3];
    int                 step_total;

    tpa_pkg::t_out_beat pending_vertices [$];
    t_vertex_row        directed_table [$];
    tpa_pkg::t_out_beat want_beat;
    int                 mismatch_count;
    int                 cycle_count;
    logic               quiet_tail;
    int                 gap_odds;

    triangle_primitive_assembler dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (o_out_beat)
    );

    always #4ns clk = ~clk;

    function automatic void add_step(input tpa_pkg::t_vertex v, input logic last);
        tpa_pkg::t_out_beat b;
        b.out_index  = v.idx;
        b.out_pos_x  = v.px;
        b.out_pos_y  = v.py;
        b.out_pos_z  = v.pz;
        b.out_norm_x = v.nx;
        b.out_norm_y = v.ny;
        b.out_norm_z = v.nz;
        b.run_last   = last;
        step_beats[step_total] = b;
        step_total++;
    endfunction

    function automatic void assemble_vertex(input tpa_pkg::t_in_beat b);
        tpa_pkg::t_vertex cur;
        logic [1:0]       slot;
        logic             par;
        step_total = 0;
        if (b.draw_mode != tpa_pkg::TRI_LIST && b.draw_mode != tpa_pkg::TRI_STRIP &&
            b.draw_mode != tpa_pkg::TRI_FAN) begin
            return;
        end
        cur.idx = b.vertex_index;
        cur.px  = b.pos_x & KEEP_MASK;
        cur.py  = b.pos_y & KEEP_MASK;
        cur.pz  = b.pos_z & KEEP_MASK;
        cur.nx  = b.norm_x & KEEP_MASK;
        cur.ny  = b.norm_y & KEEP_MASK;
        cur.nz  = b.norm_z & KEEP_MASK;
        slot = b.set_start ? 2'd0 : hist_count;
        par  = b.set_start ? 1'b0 : hist_parity;
        if (slot == 2'd0) begin
            hist_centre = cur;
        end
        if (b.draw_mode == tpa_pkg::TRI_LIST || slot < tpa_pkg::COUNT_MAX) begin
            add_step(cur, 1'b1);
        end else if (b.draw_mode == tpa_pkg::TRI_STRIP) begin
            if (par) begin
                add_step(hist_newer, 1'b0);
                add_step(hist_older, 1'b0);
            end else begin
                add_step(hist_older, 1'b0);
                add_step(hist_newer, 1'b0);
            end
            add_step(cur, 1'b1);
        end else begin
            add_step(hist_centre, 1'b0);
            add_step(hist_newer, 1'b0);
            add_step(cur, 1'b1);
        end
        hist_older  = hist_newer;
        hist_newer  = cur;
        hist_count  = (slot == tpa_pkg::COUNT_MAX) ? tpa_pkg::COUNT_MAX : slot + 2'd1;
        hist_parity = ~par;
    endfunction

    function automatic tpa_pkg::t_in_beat make_beat(input logic [3:0] mode, input logic start,
                                                    input tpa_pkg::t_word idx,
                                                    input tpa_pkg::t_word attr);
        tpa_pkg::t_in_beat b;
        b.vertex_index = idx;
        b.pos_x        = attr;
        b.pos_y        = attr ^ 32'h0000_0011;
        b.pos_z        = attr ^ 32'h0000_2200;
        b.norm_x       = attr ^ 32'h0033_0000;
        b.norm_y       = attr ^ 32'h4400_0000;
        b.norm_z       = attr ^ 32'h5500_0055;
        b.draw_mode    = mode;
        b.set_start    = start;
        return b;
    endfunction

    function automatic tpa_pkg::t_in_beat random_beat(input logic [3:0] mode,
                                                      input logic start);
        tpa_pkg::t_in_beat b;
        b.vertex_index = $urandom;
        b.pos_x        = $urandom;
        b.pos_y        = $urandom;
        b.pos_z        = $urandom;
        b.norm_x       = $urandom;
        b.norm_y       = $urandom;
        b.norm_z       = $urandom;
        b.draw_mode    = mode;
        b.set_start    = start;
        return b;
    endfunction

    function automatic void add_row(input logic [3:0] mode, input logic start,
                                    input tpa_pkg::t_word idx, input tpa_pkg::t_word attr,
                                    input t_row_kind kind);
        t_vertex_row r;
        r.beat = make_beat(mode, start, idx, attr);
        r.kind = kind;
        directed_table.insert(directed_table.size(), r);
    endfunction

    function automatic logic [3:0] pick_mode();
        case ($urandom_range(0, 2))
            0: return tpa_pkg::TRI_LIST;
            1: return tpa_pkg::TRI_STRIP;
            default: return tpa_pkg::TRI_FAN;
        endcase
    endfunction

    function automatic logic [3:0] pick_unsupported();
        case ($urandom_range(0, 6))
            0: return MODE_POINTS;
            1: return MODE_LINES;
            2: return MODE_LINE_LOOP;
            3: return MODE_LINE_STRIP;
            4: return MODE_QUADS;
            5: return MODE_QUAD_STRIP;
            default: return MODE_POLYGON;
        endcase
    endfunction

    task automatic send_vertex(input tpa_pkg::t_in_beat b, input t_row_kind kind);
        tpa_pkg::t_out_beat echo;
        if (!quiet_tail && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        @(posedge clk);
        while (o_in_stall) @(posedge clk);
        assemble_vertex(b);
        case (kind)
            ROW_ECHO: begin
                echo.out_index  = b.vertex_index;
                echo.out_pos_x  = b.pos_x;
                echo.out_pos_y  = b.pos_y;
                echo.out_pos_z  = b.pos_z;
                echo.out_norm_x = b.norm_x;
                echo.out_norm_y = b.norm_y;
                echo.out_norm_z = b.norm_z;
                echo.run_last   = 1'b1;
                pending_vertices.insert(pending_vertices.size(), echo);
            end
            ROW_DROP: begin
            end
            default: begin
                for (int k = 0; k < step_total; k++) begin
                    pending_vertices.insert(pending_vertices.size(), step_beats[k]);
                end
            end
        endcase
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input tpa_pkg::t_word want,
                               input tpa_pkg::t_word got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("%0t: %s expected %h got %h", $realtime, name, want, got);
            end
        end
    endtask

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && o_out_valid && !out_stall) begin
            if (pending_vertices.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("%0t: unexpected beat index %h", $realtime, o_out_beat.out_index);
                end
            end else begin
                want_beat = pending_vertices.pop_front();
                check_field("out_index", want_beat.out_index, o_out_beat.out_index);
                check_field("out_pos_x", want_beat.out_pos_x, o_out_beat.out_pos_x);
                check_field("out_pos_y", want_beat.out_pos_y, o_out_beat.out_pos_y);
                check_field("out_pos_z", want_beat.out_pos_z, o_out_beat.out_pos_z);
                check_field("out_norm_x", want_beat.out_norm_x, o_out_beat.out_norm_x);
                check_field("out_norm_y", want_beat.out_norm_y, o_out_beat.out_norm_y);
                check_field("out_norm_z", want_beat.out_norm_z, o_out_beat.out_norm_z);
                check_field("run_last", tpa_pkg::t_word'(want_beat.run_last),
                            tpa_pkg::t_word'(o_out_beat.run_last));
            end
        end
    end

    initial begin
        int stall_odds;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever begin
            stall_odds = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(2, 8);
            repeat (40) begin
                @(negedge clk);
                if (!quiet_tail && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
                    out_stall <= 1'b1;
                    repeat ($urandom_range(1, 19)) @(negedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    initial begin
        int         taken;
        int         set_len;
        logic [3:0] set_mode;
        logic [3:0] mode;
        logic       start;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_beat        = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        quiet_tail     = 1'b0;
        gap_odds       = 4;
        hist_older     = '0;
        hist_newer     = '0;
        hist_centre    = '0;
        hist_count     = '0;
        hist_parity    = 1'b0;

        add_row(tpa_pkg::TRI_STRIP, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, ROW_ECHO);
        add_row(tpa_pkg::TRI_STRIP, 1'b0, 32'h0000_0000, 32'h0000_0000, ROW_ECHO);
        add_row(MODE_POINTS,        1'b1, 32'h0000_0001, 32'h1234_5678, ROW_DROP);
        add_row(tpa_pkg::TRI_STRIP, 1'b0, 32'h0000_0002, 32'h2222_0002, ROW_ECHO);
        add_row(tpa_pkg::TRI_STRIP, 1'b0, 32'h0000_0003, 32'h3333_0003, ROW_MODEL);
        add_row(tpa_pkg::TRI_STRIP, 1'b0, 32'h0000_0004, 32'h4444_0004, ROW_MODEL);
        add_row(MODE_POLYGON,       1'b0, 32'h0000_0044, 32'hDEAD_BEEF, ROW_DROP);
        add_row(tpa_pkg::TRI_STRIP, 1'b0, 32'h0000_0005, 32'h5555_0005, ROW_MODEL);
        add_row(tpa_pkg::TRI_FAN,   1'b0, 32'h0000_0006, 32'h6666_0006, ROW_MODEL);
        add_row(tpa_pkg::TRI_LIST,  1'b0, 32'h0000_0007, 32'h7777_0007, ROW_ECHO);
        add_row(tpa_pkg::TRI_FAN,   1'b1, 32'h0000_000A, 32'hAAAA_000A, ROW_ECHO);
        add_row(tpa_pkg::TRI_FAN,   1'b0, 32'h0000_000B, 32'hBBBB_000B, ROW_ECHO);
        add_row(tpa_pkg::TRI_FAN,   1'b0, 32'h0000_000C, 32'hCCCC_000C, ROW_ECHO);
        add_row(tpa_pkg::TRI_FAN,   1'b0, 32'h0000_000D, 32'hDDDD_000D, ROW_MODEL);
        add_row(tpa_pkg::TRI_FAN,   1'b0, 32'h0000_000E, 32'hEEEE_000E, ROW_MODEL);
        add_row(MODE_QUAD_STRIP,    1'b1, 32'h0000_0088, 32'h8888_8888, ROW_DROP);
        add_row(MODE_LINES,         1'b0, 32'h0000_0011, 32'h1111_1111, ROW_DROP);
        add_row(tpa_pkg::TRI_STRIP, 1'b0, 32'h0000_000F, 32'hF0F0_000F, ROW_MODEL);
        add_row(tpa_pkg::TRI_LIST,  1'b1, 32'h0000_0014, 32'h1414_0014, ROW_ECHO);
        add_row(tpa_pkg::TRI_LIST,  1'b0, 32'h0000_0015, 32'h1515_0015, ROW_ECHO);
        add_row(MODE_LINE_LOOP,     1'b0, 32'h0000_0022, 32'h2020_2020, ROW_DROP);
        add_row(MODE_LINE_STRIP,    1'b1, 32'h0000_0033, 32'h3030_3030, ROW_DROP);
        add_row(MODE_QUADS,         1'b0, 32'h0000_0077, 32'h7070_7070, ROW_DROP);
        add_row(tpa_pkg::TRI_STRIP, 1'b1, 32'h0000_001E, 32'h1E1E_001E, ROW_ECHO);
        add_row(tpa_pkg::TRI_STRIP, 1'b0, 32'h0000_001F, 32'h1F1F_001F, ROW_ECHO);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_table[r]) begin
            send_vertex(directed_table[r].beat, directed_table[r].kind);
        end

        taken = 0;
        while (taken < RANDOM_ITEMS) begin
            quiet_tail = (taken >= QUIET_ITEMS);
            case ($urandom_range(0, 3))
                0: gap_odds = 0;
                1: gap_odds = 2;
                default: gap_odds = $urandom_range(4, 10);
            endcase
            if ($urandom_range(0, 9) == 0) begin
                send_vertex(random_beat(pick_unsupported(), 1'($urandom_range(0, 1))),
                            ROW_MODEL);
            end else begin
                set_mode = pick_mode();
                set_len  = $urandom_range(1, 10);
                for (int k = 0; k < set_len; k++) begin
                    mode  = ($urandom_range(0, 9) == 0) ? pick_mode() : set_mode;
                    start = (k == 0) ? ($urandom_range(0, 9) != 0)
                                     : ($urandom_range(0, 19) == 0);
                    if ($urandom_range(0, 24) == 0) begin
                        send_vertex(random_beat(pick_unsupported(), start), ROW_MODEL);
                    end
                    send_vertex(random_beat(mode, start), ROW_MODEL);
                    taken++;
                end
            end
        end
        in_valid <= 1'b0;

        while (pending_vertices.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_vertices.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/tpa_pkg.sv
src/tpa_front.sv
src/tpa_queue.sv
src/tpa_back.sv
src/triangle_primitive_assembler.sv
tb/sv/tb_triangle_primitive_assembler.sv
